// File: design/skwm_pkg.sv
// Shared types and constants for the sorted stream k-way merge unit.
package skwm_pkg;

    localparam int NUM_SOURCES = 4;
    localparam int MAX_SOURCES = 4;
    localparam int WORD_W      = 32;
    localparam int SRC_W       = 2;

    localparam logic [MAX_SOURCES-1:0] SRC_MASK = MAX_SOURCES'((1 << NUM_SOURCES) - 1);

    typedef logic [WORD_W-1:0]      t_word;
    typedef logic [SRC_W-1:0]       t_src;
    typedef logic [MAX_SOURCES-1:0] t_mask;

    typedef enum logic [1:0] {
        KIND_BEGIN   = 2'd0,
        KIND_FRAG    = 2'd1,
        KIND_EXHAUST = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_OFFSET_ONE   = 2'd0,
        CFG_OFFSET_TWO   = 2'd1,
        CFG_OFFSET_THREE = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_kind kind;
        t_src  source_index;
        t_mask active_mask;
        t_word frag_start;
        t_word frag_end;
        t_word frag_cell;
    } t_in_item;

    typedef struct packed {
        t_word merged_start;
        t_word merged_end;
        t_word merged_cell;
        t_src  from_source;
        logic  group_done;
    } t_out_item;

endpackage

// File: design/sorted_stream_kway_merge_unit.sv
// Top level of the sorted stream k-way merge unit.
// Merges up to four start-sorted fragment sources into one start-sorted stream. A begin
// item opens a group, fragment items load a per-source head, exhausted items retire a
// source; once every live source holds a head the smallest start is emitted (ties to
// the lowest source) with the source's cell offset added, and from_source names the
// source whose next fragment is wanted. A done result closes a group when its last
// source is retired or it opens with none live. Items are taken one per cycle: an input
// register feeds one pass of head update, a 4-way compare tree and the offset add into
// the result register at one item per cycle, limited only by output back pressure.
module sorted_stream_kway_merge_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  skwm_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output skwm_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_we,
    input  skwm_pkg::t_src       i_cfg_index,
    input  skwm_pkg::t_word      i_cfg_data
);

    skwm_pkg::t_word     r_offset [skwm_pkg::MAX_SOURCES];
    skwm_pkg::t_word     r_head_start [skwm_pkg::MAX_SOURCES];
    skwm_pkg::t_word     r_head_end [skwm_pkg::MAX_SOURCES];
    skwm_pkg::t_word     r_head_cell [skwm_pkg::MAX_SOURCES];
    skwm_pkg::t_mask     r_head_valid;
    skwm_pkg::t_mask     r_live;
    logic                r_in_valid;
    skwm_pkg::t_in_item  r_in;
    logic                r_out_valid;
    skwm_pkg::t_out_item r_out;

    skwm_pkg::t_mask     n_head_valid;
    skwm_pkg::t_mask     n_live;
    skwm_pkg::t_word     n_head_start [skwm_pkg::MAX_SOURCES];
    skwm_pkg::t_word     n_head_end [skwm_pkg::MAX_SOURCES];
    skwm_pkg::t_word     n_head_cell [skwm_pkg::MAX_SOURCES];
    skwm_pkg::t_mask     head_kept;
    logic                done_due;
    skwm_pkg::t_mask     src_bit;
    logic                src_live;
    logic                head_we;
    logic                try_emit;
    logic                res_valid;
    skwm_pkg::t_out_item res;
    skwm_pkg::t_src      best;
    logic                fire;

    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign src_bit  = skwm_pkg::t_mask'(1) << r_in.source_index;
    assign src_live = |(src_bit & r_live & skwm_pkg::SRC_MASK);
    assign head_we  = (r_in.kind == skwm_pkg::KIND_FRAG) && src_live;

    always_comb begin
        for (int i = 0; i < skwm_pkg::MAX_SOURCES; i++) begin
            if (head_we && (r_in.source_index == skwm_pkg::t_src'(i))) begin
                n_head_start[i] = r_in.frag_start;
                n_head_end[i]   = r_in.frag_end;
                n_head_cell[i]  = r_in.frag_cell;
            end else begin
                n_head_start[i] = r_head_start[i];
                n_head_end[i]   = r_head_end[i];
                n_head_cell[i]  = r_head_cell[i];
            end
        end
    end

    skwm_pick u_pick (
        .i_start (n_head_start),
        .i_mask  (n_live),
        .o_best  (best)
    );

    always_comb begin
        n_live    = r_live;
        head_kept = r_head_valid;
        try_emit  = 1'b0;
        done_due  = 1'b0;
        unique case (r_in.kind)
            skwm_pkg::KIND_BEGIN: begin
                n_live    = r_in.active_mask & skwm_pkg::SRC_MASK;
                head_kept = '0;
                if (n_live == '0) begin
                    done_due = 1'b1;
                end
            end
            skwm_pkg::KIND_FRAG: begin
                if (src_live) begin
                    head_kept = r_head_valid | src_bit;
                    try_emit  = 1'b1;
                end
            end
            skwm_pkg::KIND_EXHAUST: begin
                if (src_live) begin
                    n_live    = r_live & ~src_bit;
                    head_kept = r_head_valid & ~src_bit;
                    if (n_live == '0) begin
                        done_due = 1'b1;
                    end else begin
                        try_emit = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_head_valid   = head_kept;
        res_valid      = done_due;
        res            = '0;
        res.group_done = done_due;
        // emit once every live source has a head
        if (try_emit && (n_live != '0) && ((head_kept & n_live) == n_live)) begin
            res_valid        = 1'b1;
            res.merged_start = n_head_start[best];
            res.merged_end   = n_head_end[best];
            res.merged_cell  = n_head_cell[best] + r_offset[best];
            res.from_source  = best;
            res.group_done   = 1'b0;
            n_head_valid     = head_kept & ~(skwm_pkg::t_mask'(1) << best);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_live       <= '0;
            r_head_valid <= '0;
            r_offset     <= '{default: '0};
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_live       <= n_live;
                r_head_valid <= n_head_valid;
            end
            if (fire && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    skwm_pkg::CFG_OFFSET_ONE:   r_offset[1] <= i_cfg_data;
                    skwm_pkg::CFG_OFFSET_TWO:   r_offset[2] <= i_cfg_data;
                    skwm_pkg::CFG_OFFSET_THREE: r_offset[3] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (fire && res_valid) begin
            r_out <= res;
        end
        if (fire && head_we) begin
            r_head_start[r_in.source_index] <= r_in.frag_start;
            r_head_end[r_in.source_index]   <= r_in.frag_end;
            r_head_cell[r_in.source_index]  <= r_in.frag_cell;
        end
    end

`ifndef SYNTHESIS
    a_head_within_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head_valid & ~r_live) == '0)
        else $error("head held for a source that is not live");

    a_live_within_sources: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_live & ~skwm_pkg::SRC_MASK) == '0)
        else $error("live source beyond configured source count");

    a_done_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.group_done) |->
            (r_out.merged_start == '0 && r_out.merged_end == '0 &&
             r_out.merged_cell == '0 && r_out.from_source == '0))
        else $error("done item carries fragment data");

    a_emitted_head_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res_valid && !res.group_done) |=> !r_head_valid[$past(best)])
        else $error("emitted head still marked valid");

    a_emit_needs_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res_valid && !res.group_done) |-> n_live[best])
        else $error("emitted source is not live");
`endif

endmodule

// File: design/skwm_pick.sv
// Four-way minimum tree over the head starts of the live sources.
module skwm_pick (
    input  skwm_pkg::t_word i_start [skwm_pkg::MAX_SOURCES],
    input  skwm_pkg::t_mask i_mask,
    output skwm_pkg::t_src  o_best
);

    logic           lo_pick;
    logic           hi_pick;
    logic           lo_any;
    logic           hi_any;
    skwm_pkg::t_src lo_idx;
    skwm_pkg::t_src hi_idx;
    skwm_pkg::t_word lo_start;
    skwm_pkg::t_word hi_start;

    // Within a pair the higher index wins only on a strictly smaller start.
    always_comb begin
        lo_pick  = !i_mask[0] || (i_mask[1] && (i_start[1] < i_start[0]));
        hi_pick  = !i_mask[2] || (i_mask[3] && (i_start[3] < i_start[2]));
        lo_idx   = lo_pick ? skwm_pkg::t_src'(1) : skwm_pkg::t_src'(0);
        hi_idx   = hi_pick ? skwm_pkg::t_src'(3) : skwm_pkg::t_src'(2);
        lo_start = lo_pick ? i_start[1] : i_start[0];
        hi_start = hi_pick ? i_start[3] : i_start[2];
        lo_any   = i_mask[0] || i_mask[1];
        hi_any   = i_mask[2] || i_mask[3];
        if (!lo_any || (hi_any && (hi_start < lo_start))) begin
            o_best = hi_idx;
        end else begin
            o_best = lo_idx;
        end
    end

endmodule

// File: test/sorted_stream_kway_merge_unit_tb.sv
// Testbench for the sorted stream k-way merge unit: directed table, random groups, self-check.
`timescale 1ns / 100ps

module sorted_stream_kway_merge_unit_tb;

    localparam int NUM_DIR   = 27;
    localparam int PHASE_LEN = 225;
    localparam int LIMIT     = 400000;
    localparam skwm_pkg::t_out_item DONE_RES = '{merged_start: '0, merged_end: '0,
                                                 merged_cell: '0, from_source: '0,
                                                 group_done: 1'b1};

    typedef struct packed {
        skwm_pkg::t_in_item it;
        logic               done_row;
    } t_dir_row;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    skwm_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_ready;
    skwm_pkg::t_out_item out_item;
    logic                cfg_we;
    skwm_pkg::t_src      cfg_index;
    skwm_pkg::t_word     cfg_data;

    // predictor state
    skwm_pkg::t_word hd_start [4];
    skwm_pkg::t_word hd_end [4];
    skwm_pkg::t_word hd_cell [4];
    skwm_pkg::t_mask head_held;
    skwm_pkg::t_mask live_src;
    skwm_pkg::t_word cell_off [4];

    // random group feeder state
    int              frags_left [4];
    skwm_pkg::t_word run_start [4];

    skwm_pkg::t_out_item merged_due [$];
    int        errors;
    int        cycles;
    int        items_sent;
    int        results_seen;
    int        dones_seen;
    int        groups_begun;
    bit        quiet;
    int        stall_left;

    sorted_stream_kway_merge_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     merged_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(negedge clk) begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (!quiet && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 9);
        out_ready <= (stall_left == 0);
    end

    task automatic report(input string what, input skwm_pkg::t_out_item want,
                          input skwm_pkg::t_out_item got);
        errors = errors + 1;
        if (errors <= 10)
            $display("%s: start %h/%h end %h/%h cell %h/%h src %0d/%0d done %0b/%0b (want/got)",
                     what, want.merged_start, got.merged_start, want.merged_end,
                     got.merged_end, want.merged_cell, got.merged_cell, want.from_source,
                     got.from_source, want.group_done, got.group_done);
    endtask

    always @(posedge clk) begin
        skwm_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            results_seen = results_seen + 1;
            if (out_item.group_done)
                dones_seen = dones_seen + 1;
            if (merged_due.size() == 0) begin
                report("unexpected item", '0, out_item);
            end else begin
                want = merged_due.pop_front();
                if (out_item.merged_start !== want.merged_start ||
                    out_item.merged_end !== want.merged_end ||
                    out_item.merged_cell !== want.merged_cell ||
                    out_item.from_source !== want.from_source ||
                    out_item.group_done !== want.group_done)
                    report("mismatch", want, out_item);
            end
        end
    end

    // Emit the smallest start once every live source holds a head; ties to lowest index.
    task automatic emit_smallest(output bit has, output skwm_pkg::t_out_item res);
        int best;
        has = 1'b0;
        res = '0;
        best = -1;
        if (live_src != '0 && (head_held & live_src) == live_src) begin
            for (int s = 0; s < skwm_pkg::NUM_SOURCES; s++)
                if (live_src[s] && (best < 0 || hd_start[s] < hd_start[best]))
                    best = s;
            res.merged_start = hd_start[best];
            res.merged_end   = hd_end[best];
            res.merged_cell  = hd_cell[best] + cell_off[best];
            res.from_source  = skwm_pkg::t_src'(best);
            head_held[best]  = 1'b0;
            has = 1'b1;
        end
    endtask

    task automatic merge_step(input skwm_pkg::t_in_item it, output bit has,
                              output skwm_pkg::t_out_item res);
        int              s;
        skwm_pkg::t_mask sel;
        bit              is_live;
        has = 1'b0;
        res = '0;
        s = int'(it.source_index);
        sel = skwm_pkg::t_mask'(1) << s;
        is_live = (s < skwm_pkg::NUM_SOURCES) && ((live_src & sel) != '0);
        case (it.kind)
            skwm_pkg::KIND_BEGIN: begin
                live_src = it.active_mask & skwm_pkg::SRC_MASK;
                head_held = '0;
                if (live_src == '0) begin
                    has = 1'b1;
                    res = DONE_RES;
                end
            end
            skwm_pkg::KIND_FRAG: begin
                if (is_live) begin
                    hd_start[s] = it.frag_start;
                    hd_end[s]   = it.frag_end;
                    hd_cell[s]  = it.frag_cell;
                    head_held   = head_held | sel;
                    emit_smallest(has, res);
                end
            end
            skwm_pkg::KIND_EXHAUST: begin
                if (is_live) begin
                    live_src  = live_src & ~sel;
                    head_held = head_held & ~sel;
                    if (live_src == '0) begin
                        has = 1'b1;
                        res = DONE_RES;
                    end else begin
                        emit_smallest(has, res);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input skwm_pkg::t_in_item it, input bit done_row);
        bit                  has;
        skwm_pkg::t_out_item res;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge clk); while (!in_ready);
        merge_step(it, has, res);
        if (done_row) begin
            has = 1'b1;
            res = DONE_RES;
        end
        if (has)
            merged_due = {merged_due, res};
        if (it.kind == skwm_pkg::KIND_BEGIN)
            groups_begun = groups_begun + 1;
        items_sent = items_sent + 1;
    endtask

    // Offsets change only with nothing in flight.
    task automatic write_offsets(input skwm_pkg::t_word one, input skwm_pkg::t_word two,
                                 input skwm_pkg::t_word three);
        @(negedge clk);
        in_valid = 1'b0;
        while (merged_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = skwm_pkg::CFG_OFFSET_ONE;
        cfg_data = one;
        cell_off[1] = one;
        @(negedge clk);
        cfg_index = skwm_pkg::CFG_OFFSET_TWO;
        cfg_data = two;
        cell_off[2] = two;
        @(negedge clk);
        cfg_index = skwm_pkg::CFG_OFFSET_THREE;
        cfg_data = three;
        cell_off[3] = three;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic skwm_pkg::t_in_item mk(input skwm_pkg::t_kind k, input int s,
                                              input skwm_pkg::t_mask m,
                                              input skwm_pkg::t_word st,
                                              input skwm_pkg::t_word en,
                                              input skwm_pkg::t_word ce);
        skwm_pkg::t_in_item it;
        it.kind = k;
        it.source_index = skwm_pkg::t_src'(s);
        it.active_mask = m;
        it.frag_start = st;
        it.frag_end = en;
        it.frag_cell = ce;
        return it;
    endfunction

    function automatic t_dir_row dir_row(input int n);
        t_dir_row r;
        r.done_row = 1'b0;
        case (n)
            0:  begin
                r.it = mk(skwm_pkg::KIND_BEGIN, 0, 4'h0, 0, 0, 0);
                r.done_row = 1'b1;
            end
            1:  r.it = mk(skwm_pkg::KIND_BEGIN, 0, 4'hF, 0, 0, 0);
            2:  r.it = mk(skwm_pkg::KIND_FRAG, 0, 4'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF);
            3:  r.it = mk(skwm_pkg::KIND_FRAG, 1, 4'h0, 0, 0, 0);
            4:  r.it = mk(skwm_pkg::KIND_FRAG, 2, 4'h0, 0, 5, 7);
            // tie on start zero goes to source one
            5:  r.it = mk(skwm_pkg::KIND_FRAG, 3, 4'h0, 0, 9, 32'hFFFF_FFFF);
            // overwrite of a held head
            6:  r.it = mk(skwm_pkg::KIND_FRAG, 2, 4'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
            7:  r.it = mk(skwm_pkg::KIND_FRAG, 1, 4'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
            8:  r.it = mk(skwm_pkg::KIND_EXHAUST, 3, 4'h0, 0, 0, 0);
            9:  r.it = mk(skwm_pkg::KIND_EXHAUST, 0, 4'h0, 0, 0, 0);
            // retiring a loaded source drops its head
            10: r.it = mk(skwm_pkg::KIND_EXHAUST, 2, 4'h0, 0, 0, 0);
            11: r.it = mk(skwm_pkg::KIND_FRAG, 2, 4'h0, 1, 2, 3);
            12: r.it = mk(skwm_pkg::KIND_EXHAUST, 3, 4'h0, 0, 0, 0);
            13: r.it = mk(skwm_pkg::KIND_FRAG, 1, 4'h0, 32'h1234, 32'h5678, 32'hFFFF_FFFF);
            14: begin
                r.it = mk(skwm_pkg::KIND_EXHAUST, 1, 4'h0, 0, 0, 0);
                r.done_row = 1'b1;
            end
            15: r.it = mk(skwm_pkg::KIND_EXHAUST, 0, 4'h0, 0, 0, 0);
            16: r.it = mk(skwm_pkg::KIND_BEGIN, 0, 4'b1010, 0, 0, 0);
            17: r.it = mk(skwm_pkg::KIND_FRAG, 1, 4'h0, 10, 20, 30);
            // a begin abandons the open group
            18: r.it = mk(skwm_pkg::KIND_BEGIN, 3, 4'b0101, 0, 0, 0);
            19: r.it = mk(skwm_pkg::KIND_FRAG, 0, 4'h0, 5, 6, 32'h8000_0000);
            20: r.it = mk(skwm_pkg::KIND_FRAG, 2, 4'h0, 3, 4, 32'h8000_0000);
            21: r.it = mk(skwm_pkg::KIND_FRAG, 2, 4'h0, 8, 9, 32'h7FFF_FFFF);
            22: r.it = mk(skwm_pkg::KIND_EXHAUST, 0, 4'h0, 0, 0, 0);
            23: begin
                r.it = mk(skwm_pkg::KIND_EXHAUST, 2, 4'h0, 0, 0, 0);
                r.done_row = 1'b1;
            end
            24: r.it = mk(skwm_pkg::KIND_BEGIN, 1, 4'b1000, 0, 0, 0);
            25: r.it = mk(skwm_pkg::KIND_FRAG, 3, 4'hF, 32'hFFFF_FFFF, 0, 32'h8000_0000);
            default: begin
                r.it = mk(skwm_pkg::KIND_EXHAUST, 3, 4'h0, 0, 0, 0);
                r.done_row = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Mostly well-formed groups: feed whichever live source lacks a head.
    task automatic make_random(output skwm_pkg::t_in_item it);
        skwm_pkg::t_mask open_m;
        int              s;
        it.kind = skwm_pkg::KIND_FRAG;
        it.source_index = skwm_pkg::t_src'($urandom_range(0, 3));
        it.active_mask = skwm_pkg::t_mask'($urandom_range(0, 15));
        it.frag_start = $urandom;
        it.frag_end = $urandom;
        it.frag_cell = $urandom;
        if ($urandom_range(0, 99) < 15) begin
            if ($urandom_range(0, 7) == 0)
                it.kind = skwm_pkg::KIND_BEGIN;
            else
                it.kind = $urandom_range(0, 1) ? skwm_pkg::KIND_FRAG : skwm_pkg::KIND_EXHAUST;
        end else if (live_src == '0) begin
            it.kind = skwm_pkg::KIND_BEGIN;
            if ($urandom_range(0, 15) != 0)
                it.active_mask = skwm_pkg::t_mask'($urandom_range(1, 15));
            else
                it.active_mask = '0;
        end else begin
            open_m = live_src & ~head_held;
            s = $urandom_range(0, 3);
            while (!open_m[s])
                s = (s + 1) % 4;
            it.source_index = skwm_pkg::t_src'(s);
            if (frags_left[s] == 0) begin
                it.kind = skwm_pkg::KIND_EXHAUST;
            end else begin
                frags_left[s] = frags_left[s] - 1;
                run_start[s] = run_start[s] + $urandom_range(0, 3);
                if ($urandom_range(0, 19) != 0)
                    it.frag_start = run_start[s];
                it.frag_end = it.frag_start + $urandom_range(0, 1000);
            end
        end
        if (it.kind == skwm_pkg::KIND_BEGIN) begin
            for (int k = 0; k < 4; k++) begin
                frags_left[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                             : $urandom_range(0, 6);
                run_start[k] = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFF0
                                                            : $urandom_range(0, 50);
            end
        end
    endtask

    initial begin
        skwm_pkg::t_in_item it;
        t_dir_row           r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b1;
        cfg_we = 1'b0;
        cfg_index = skwm_pkg::CFG_OFFSET_ONE;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        items_sent = 0;
        results_seen = 0;
        dones_seen = 0;
        groups_begun = 0;
        quiet = 1'b0;
        stall_left = 0;
        head_held = '0;
        live_src = '0;
        for (int k = 0; k < 4; k++) begin
            cell_off[k] = '0;
            frags_left[k] = 0;
            run_start[k] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        write_offsets(32'hFFFF_FFFF, 32'h1, 32'h8000_0000);
        for (int n = 0; n < NUM_DIR; n++) begin
            r = dir_row(n);
            send_item(r.it, r.done_row);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_offsets('0, '0, '0);
                1: write_offsets(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default: write_offsets($urandom, $urandom, $urandom);
            endcase
            // last phase runs at full rate on both sides
            if (ph == 3)
                quiet = 1'b1;
            repeat (PHASE_LEN) begin
                make_random(it);
                send_item(it, 1'b0);
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (merged_due.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (merged_due.size() != 0) begin
            errors = errors + merged_due.size();
            $display("%0d results never arrived", merged_due.size());
        end
        $display("%0d items in, %0d groups opened, %0d results out (%0d done)",
                 items_sent, groups_begun, results_seen, dones_seen);
        $display("5 offset settings incl. zero and all-ones, %0d errors", errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
